FILE: rtl/core/block_test_address_generator_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the address generator core
// Clocked on i_clk, disabled while i_rst_n is low
// ----------------------------------------------------------------------------
`ifndef BLOCK_TEST_ADDRESS_GENERATOR_CORE_ASSERT_SVH
`define BLOCK_TEST_ADDRESS_GENERATOR_CORE_ASSERT_SVH

// antecedent and consequent in the same cycle
`define BTAG_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("btag check failed: same-cycle implication");

// consequent in the cycle after the antecedent
`define BTAG_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("btag check failed: next-cycle implication");

`endif

FILE: rtl/core/btag_pkg.sv
// ----------------------------------------------------------------------------
// btag_pkg
// Shared types, constants and the LFSR tap table of the address generator
// ----------------------------------------------------------------------------
package btag_pkg;

    localparam int ADDR_WIDTH_DEF = 48;
    localparam int MAX_ORDER_DEF  = 32;
    localparam int MIN_ORDER      = 8;
    localparam int POS_W          = 32;
    localparam int STRIDE_W       = 32;
    localparam int PROD_W         = POS_W + STRIDE_W;
    localparam int SIZE_W         = 31;
    localparam int ORDER_W        = 6;
    localparam int CFG_IDX_W      = 3;

    localparam logic [31:0] SEED_PATTERN = 32'h0000_ace1;

    localparam logic [SIZE_W-1:0]  BLOCK_SIZE_RST = 31'd4096;
    localparam logic [SIZE_W-1:0]  ALIGN_RST      = 31'd0;
    localparam logic [31:0]        PASS_COUNT_RST = 32'd1;
    localparam logic [ORDER_W-1:0] ORDER_RST      = 6'd16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BLOCK_SIZE  = 3'd0,
        CFG_ALIGN_BYTES = 3'd1,
        CFG_BASE_OFFSET = 3'd2,
        CFG_PASS_COUNT  = 3'd3,
        CFG_LFSR_ORDER  = 3'd4,
        CFG_RANDOM_MODE = 3'd5
    } t_cfg_idx;

    // settings the sequencer needs
    typedef struct packed {
        logic [SIZE_W-1:0]  block_size;
        logic [SIZE_W-1:0]  align_bytes;
        logic [31:0]        pass_count;
        logic [ORDER_W-1:0] lfsr_order;
        logic               random_mode;
    } t_seq_cfg;

    // one position on its way to the address stage
    typedef struct packed {
        logic [POS_W-1:0]    pos;
        logic [STRIDE_W-1:0] stride;
        logic                pass_end;
    } t_pos_item;

    // feedback taps for orders 8..32
    function automatic logic [31:0] tap_mask(input logic [ORDER_W-1:0] order);
        logic [31:0] m;
        case (order)
            6'd8:    m = 32'h0000_001D;
            6'd9:    m = 32'h0000_0011;
            6'd10:   m = 32'h0000_0009;
            6'd11:   m = 32'h0000_0005;
            6'd12:   m = 32'h0000_0107;
            6'd13:   m = 32'h0000_0027;
            6'd14:   m = 32'h0000_1007;
            6'd15:   m = 32'h0000_0003;
            6'd16:   m = 32'h0000_002D;
            6'd17:   m = 32'h0000_0009;
            6'd18:   m = 32'h0000_0081;
            6'd19:   m = 32'h0000_0027;
            6'd20:   m = 32'h0000_0009;
            6'd21:   m = 32'h0000_0005;
            6'd22:   m = 32'h0000_0003;
            6'd23:   m = 32'h0000_0021;
            6'd24:   m = 32'h0000_0087;
            6'd25:   m = 32'h0000_0009;
            6'd26:   m = 32'h0310_0001;
            6'd27:   m = 32'h0640_0001;
            6'd28:   m = 32'h0000_0009;
            6'd29:   m = 32'h0000_0005;
            6'd30:   m = 32'h2500_0001;
            6'd31:   m = 32'h0000_0009;
            6'd32:   m = 32'hC000_0401;
            default: m = 32'h0000_001D;
        endcase
        return m;
    endfunction

endpackage

FILE: rtl/core/btag_seq.sv
// ----------------------------------------------------------------------------
// btag_seq
// Pass index, LFSR position and stride for each request, one per cycle while the next stage accepts
// ----------------------------------------------------------------------------
module btag_seq #(
    parameter int MAX_ORDER = btag_pkg::MAX_ORDER_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  btag_pkg::t_seq_cfg   i_cfg,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic                 i_restart,
    output logic                 o_valid,
    input  logic                 i_ready,
    output btag_pkg::t_pos_item  o_item
);

    localparam int ORDER_W = btag_pkg::ORDER_W;

    logic                          r_valid;
    btag_pkg::t_pos_item           r_item;
    logic [31:0]                   r_pass_index;
    logic [MAX_ORDER-1:0]          r_lfsr;

    logic                          w_xfer;
    logic [ORDER_W-1:0]            w_order;
    logic [MAX_ORDER-1:0]          w_mask;
    logic [MAX_ORDER-1:0]          w_top;
    logic [MAX_ORDER-1:0]          w_seed;
    logic [MAX_ORDER-1:0]          w_taps;
    logic [MAX_ORDER-1:0]          w_base;
    logic [MAX_ORDER-1:0]          w_v;
    logic [MAX_ORDER-1:0]          w_step;
    logic [MAX_ORDER-1:0]          w_lfsr_out;
    logic                          w_fb;
    logic [MAX_ORDER-1:0]          n_lfsr;
    logic [31:0]                   w_idx;
    logic [32:0]                   w_idx_inc;
    logic [32:0]                   w_limit;
    logic                          w_end;
    logic [31:0]                   n_pass_index;
    logic [btag_pkg::STRIDE_W-1:0] w_sz;
    logic [btag_pkg::STRIDE_W-1:0] w_al;
    logic [btag_pkg::STRIDE_W-1:0] w_round;
    logic [btag_pkg::STRIDE_W-1:0] w_stride;
    btag_pkg::t_pos_item           n_item;

    assign o_ready = !r_valid || i_ready;
    assign w_xfer  = i_valid && o_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    // order clamped to the supported range
    always_comb begin
        if (i_cfg.lfsr_order < ORDER_W'(btag_pkg::MIN_ORDER)) begin
            w_order = ORDER_W'(btag_pkg::MIN_ORDER);
        end else if (i_cfg.lfsr_order > ORDER_W'(MAX_ORDER)) begin
            w_order = ORDER_W'(MAX_ORDER);
        end else begin
            w_order = i_cfg.lfsr_order;
        end
    end

    always_comb begin
        for (int i = 0; i < MAX_ORDER; i++) begin
            w_mask[i] = (ORDER_W'(i) < w_order);
            w_top[i]  = (ORDER_W'(i) == w_order - ORDER_W'(1));
        end
    end

    assign w_seed = w_mask & MAX_ORDER'(btag_pkg::SEED_PATTERN);
    assign w_taps = MAX_ORDER'(btag_pkg::tap_mask(w_order));
    assign w_base = i_restart ? '0 : r_lfsr;
    assign w_v    = w_base & w_mask;

    // zero stands in for the seed, and the seed steps to zero
    always_comb begin
        w_step     = (w_v == '0) ? w_seed : w_v;
        w_fb       = ^(w_step & w_taps);
        w_lfsr_out = (w_step >> 1) | (w_fb ? w_top : '0);
        if (w_v == w_seed) begin
            w_lfsr_out = '0;
        end
    end

    assign n_lfsr = i_cfg.random_mode ? w_lfsr_out : w_base;

    assign w_idx        = i_restart ? 32'd0 : r_pass_index;
    assign w_idx_inc    = {1'b0, w_idx} + 33'd1;
    assign w_limit      = (i_cfg.pass_count == 32'd0) ? 33'd1 : {1'b0, i_cfg.pass_count};
    assign w_end        = (w_idx_inc >= w_limit);
    assign n_pass_index = w_end ? 32'd0 : w_idx_inc[31:0];

    // block size rounded up to alignment, one unit more if aligned; zero alignment keeps it
    assign w_sz    = {1'b0, i_cfg.block_size};
    assign w_al    = {1'b0, i_cfg.align_bytes};
    assign w_round = (w_sz + w_al - 32'd1) & ~(w_al - 32'd1);

    always_comb begin
        if (w_al == '0) begin
            w_stride = w_sz;
        end else if (w_round == w_sz) begin
            w_stride = w_round + w_al;
        end else begin
            w_stride = w_round;
        end
    end

    always_comb begin
        n_item.pos      = i_cfg.random_mode ? btag_pkg::POS_W'(w_lfsr_out) : w_idx;
        n_item.stride   = w_stride;
        n_item.pass_end = w_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_pass_index <= '0;
            r_lfsr       <= '0;
        end else begin
            if (o_ready) begin
                r_valid <= i_valid;
            end
            if (w_xfer) begin
                r_pass_index <= n_pass_index;
                r_lfsr       <= n_lfsr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_xfer) begin
            r_item <= n_item;
        end
    end

endmodule

FILE: rtl/core/btag_calc.sv
// ----------------------------------------------------------------------------
// btag_calc
// Position times stride, then plus the base offset, two registered stages
// ----------------------------------------------------------------------------
module btag_calc #(
    parameter int ADDR_WIDTH = btag_pkg::ADDR_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  btag_pkg::t_pos_item         i_item,
    input  logic [ADDR_WIDTH-1:0]       i_base_offset,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [ADDR_WIDTH-1:0]       o_byte_address,
    output logic [btag_pkg::POS_W-1:0]  o_block_position,
    output logic                        o_pass_end
);

    logic                        r_v2;
    logic [ADDR_WIDTH-1:0]       r_prod;
    logic [btag_pkg::POS_W-1:0]  r_pos2;
    logic                        r_end2;
    logic                        r_v3;
    logic [ADDR_WIDTH-1:0]       r_addr;
    logic [btag_pkg::POS_W-1:0]  r_pos3;
    logic                        r_end3;

    logic                        w_rdy2;
    logic                        w_rdy3;
    logic [btag_pkg::PROD_W-1:0] w_prod;

    assign w_rdy3  = !r_v3 || i_ready;
    assign w_rdy2  = !r_v2 || w_rdy3;
    assign o_ready = w_rdy2;

    assign w_prod = {{btag_pkg::STRIDE_W{1'b0}}, i_item.pos}
                  * {{btag_pkg::POS_W{1'b0}}, i_item.stride};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_rdy2) begin
                r_v2 <= i_valid;
            end
            if (w_rdy3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && w_rdy2) begin
            r_prod <= w_prod[ADDR_WIDTH-1:0];
            r_pos2 <= i_item.pos;
            r_end2 <= i_item.pass_end;
        end
        if (r_v2 && w_rdy3) begin
            r_addr <= r_prod + i_base_offset;
            r_pos3 <= r_pos2;
            r_end3 <= r_end2;
        end
    end

    assign o_valid          = r_v3;
    assign o_byte_address   = r_addr;
    assign o_block_position = r_pos3;
    assign o_pass_end       = r_end3;

endmodule

FILE: rtl/core/block_test_address_generator_core.sv
// ----------------------------------------------------------------------------
// block_test_address_generator_core
// Access address generator for storage benchmark traffic
// ----------------------------------------------------------------------------
// Usage:
//   Request channel i_in_valid/o_in_ready carries i_restart; each transfer
//   yields exactly one result on o_out_valid/i_out_ready: byte address,
//   block position and the end-of-pass flag.
//   Settings are written through i_cfg_we/i_cfg_index/i_cfg_data; the user must write them only while no
//   request is in flight (the block does not enforce this); they take effect for the next request.
//   Stages: each request passes the sequencer stage, the multiply stage and
//   the offset add stage, each registered, before its result is valid.
//   Throughput: one request per cycle while i_out_ready is high; the pass index steps once
//   per transfer in the sequencer stage, and the LFSR too in random mode.
//   Stall: when i_out_ready is low, the stages fill and hold their items;
//   o_in_ready drops once all three stages are occupied. Nothing is lost.
//   Reset (synchronous, active low): pass index and LFSR cleared, settings
//   back to their defaults, all stages empty.
// ----------------------------------------------------------------------------
`include "block_test_address_generator_core_assert.svh"

module block_test_address_generator_core #(
    parameter int ADDR_WIDTH = btag_pkg::ADDR_WIDTH_DEF,
    parameter int MAX_ORDER  = btag_pkg::MAX_ORDER_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [btag_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [ADDR_WIDTH-1:0]             i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_restart,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [ADDR_WIDTH-1:0]             o_byte_address,
    output logic [btag_pkg::POS_W-1:0]        o_block_position,
    output logic                              o_pass_end
);

    logic [btag_pkg::SIZE_W-1:0]  r_block_size;
    logic [btag_pkg::SIZE_W-1:0]  r_align_bytes;
    logic [ADDR_WIDTH-1:0]        r_base_offset;
    logic [31:0]                  r_pass_count;
    logic [btag_pkg::ORDER_W-1:0] r_lfsr_order;
    logic                         r_random_mode;

    btag_pkg::t_seq_cfg           w_seq_cfg;
    logic                         w_s1_valid;
    logic                         w_s1_ready;
    btag_pkg::t_pos_item          w_s1_item;
    logic                         w_in_xfer;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_size  <= btag_pkg::BLOCK_SIZE_RST;
            r_align_bytes <= btag_pkg::ALIGN_RST;
            r_base_offset <= '0;
            r_pass_count  <= btag_pkg::PASS_COUNT_RST;
            r_lfsr_order  <= btag_pkg::ORDER_RST;
            r_random_mode <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (btag_pkg::t_cfg_idx'(i_cfg_index))
                btag_pkg::CFG_BLOCK_SIZE:  r_block_size  <= i_cfg_data[btag_pkg::SIZE_W-1:0];
                btag_pkg::CFG_ALIGN_BYTES: r_align_bytes <= i_cfg_data[btag_pkg::SIZE_W-1:0];
                btag_pkg::CFG_BASE_OFFSET: r_base_offset <= i_cfg_data;
                btag_pkg::CFG_PASS_COUNT:  r_pass_count  <= i_cfg_data[31:0];
                btag_pkg::CFG_LFSR_ORDER:  r_lfsr_order  <= i_cfg_data[btag_pkg::ORDER_W-1:0];
                btag_pkg::CFG_RANDOM_MODE: r_random_mode <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        w_seq_cfg.block_size  = r_block_size;
        w_seq_cfg.align_bytes = r_align_bytes;
        w_seq_cfg.pass_count  = r_pass_count;
        w_seq_cfg.lfsr_order  = r_lfsr_order;
        w_seq_cfg.random_mode = r_random_mode;
    end

    assign w_in_xfer = i_in_valid && o_in_ready;

    btag_seq #(
        .MAX_ORDER (MAX_ORDER)
    ) u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (w_seq_cfg),
        .i_valid   (i_in_valid),
        .o_ready   (o_in_ready),
        .i_restart (i_restart),
        .o_valid   (w_s1_valid),
        .i_ready   (w_s1_ready),
        .o_item    (w_s1_item)
    );

    btag_calc #(
        .ADDR_WIDTH (ADDR_WIDTH)
    ) u_calc (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (w_s1_valid),
        .o_ready          (w_s1_ready),
        .i_item           (w_s1_item),
        .i_base_offset    (r_base_offset),
        .o_valid          (o_out_valid),
        .i_ready          (i_out_ready),
        .o_byte_address   (o_byte_address),
        .o_block_position (o_block_position),
        .o_pass_end       (o_pass_end)
    );

    // every request transfer lands in the sequencer stage
    `BTAG_ASSERT_NEXT(a_xfer_lands, w_in_xfer, w_s1_valid)
    // a sequential restart starts the pass at position zero
    `BTAG_ASSERT_NEXT(a_restart_pos, w_in_xfer && i_restart && !r_random_mode, w_s1_item.pos == '0)
    // a sequencer item blocked by the address stage stays put
    `BTAG_ASSERT_NEXT(a_s1_hold, w_s1_valid && !w_s1_ready, w_s1_valid && $stable(w_s1_item))

endmodule

FILE: sim/tb_block_test_address_generator_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_block_test_address_generator_core
// Drives address requests through the valid/ready request channel, programs
// the settings between phases and checks every address, position and
// end-of-pass flag against an in-bench model of the stride, pass index and
// LFSR sequencing, with and without random stalls on both channels
// ----------------------------------------------------------------------------

typedef struct packed {
    logic [47:0] addr;
    logic [31:0] pos;
    logic        last_of_pass;
} t_access;

class addr_scoreboard;
    logic [30:0] block_size;
    logic [30:0] align_bytes;
    logic [47:0] base_offset;
    logic [31:0] pass_count;
    logic [5:0]  lfsr_order;
    logic        random_mode;
    logic [31:0] pass_index;
    logic [31:0] lfsr_state;
    logic [31:0] feedback_taps [25];
    t_access     expected_q[$];
    int          errors;

    function new();
        block_size    = btag_pkg::BLOCK_SIZE_RST;
        align_bytes   = btag_pkg::ALIGN_RST;
        base_offset   = '0;
        pass_count    = btag_pkg::PASS_COUNT_RST;
        lfsr_order    = btag_pkg::ORDER_RST;
        random_mode   = 1'b0;
        pass_index    = '0;
        lfsr_state    = '0;
        errors        = 0;
        // taps for orders 8 through 32
        feedback_taps = '{
            32'h0000001D, 32'h00000011, 32'h00000009, 32'h00000005, 32'h00000107,
            32'h00000027, 32'h00001007, 32'h00000003, 32'h0000002D, 32'h00000009,
            32'h00000081, 32'h00000027, 32'h00000009, 32'h00000005, 32'h00000003,
            32'h00000021, 32'h00000087, 32'h00000009, 32'h03100001, 32'h06400001,
            32'h00000009, 32'h00000005, 32'h25000001, 32'h00000009, 32'hC0000401
        };
    endfunction

    function void apply_setting(logic [btag_pkg::CFG_IDX_W-1:0] idx, logic [47:0] d);
        case (idx)
            btag_pkg::CFG_BLOCK_SIZE:  block_size  = d[30:0];
            btag_pkg::CFG_ALIGN_BYTES: align_bytes = d[30:0];
            btag_pkg::CFG_BASE_OFFSET: base_offset = d;
            btag_pkg::CFG_PASS_COUNT:  pass_count  = d[31:0];
            btag_pkg::CFG_LFSR_ORDER:  lfsr_order  = d[5:0];
            btag_pkg::CFG_RANDOM_MODE: random_mode = d[0];
            default: ;
        endcase
    endfunction

    function logic [31:0] lfsr_advance(logic [31:0] v, int unsigned order);
        logic [63:0] wmask;
        logic [31:0] seed;
        logic [31:0] cur;
        logic        fb;
        wmask = (64'd1 << order) - 64'd1;
        seed  = wmask[31:0] & btag_pkg::SEED_PATTERN;
        cur   = v & wmask[31:0];
        // the seed value maps to zero and zero resumes from the seed
        if (cur == seed)
            return 32'd0;
        if (cur == 32'd0)
            cur = seed;
        fb = ^(cur & feedback_taps[(order - btag_pkg::MIN_ORDER) % 25]);
        return (cur >> 1) | ({31'd0, fb} << (order - 1));
    endfunction

    function logic [63:0] stride_bytes();
        logic [63:0] sz;
        logic [63:0] al;
        logic [63:0] r;
        sz = {33'd0, block_size};
        al = {33'd0, align_bytes};
        if (al == 64'd0)
            return sz;
        r = (sz + al - 64'd1) & ~(al - 64'd1);
        if (r == sz)
            r = r + al;
        return r;
    endfunction

    function void note_request(logic restart);
        t_access     acc;
        int unsigned order;
        logic [31:0] pos;
        logic [32:0] next_index;
        logic [32:0] limit;
        logic [63:0] sum;
        if (restart) begin
            pass_index = '0;
            lfsr_state = '0;
        end
        order = lfsr_order;
        if (order < btag_pkg::MIN_ORDER)
            order = btag_pkg::MIN_ORDER;
        if (order > btag_pkg::MAX_ORDER_DEF)
            order = btag_pkg::MAX_ORDER_DEF;
        if (random_mode) begin
            lfsr_state = lfsr_advance(lfsr_state, order);
            pos = lfsr_state;
        end else begin
            pos = pass_index;
        end
        next_index = {1'b0, pass_index} + 33'd1;
        limit = (pass_count == 32'd0) ? 33'd1 : {1'b0, pass_count};
        acc.last_of_pass = (next_index >= limit);
        pass_index = acc.last_of_pass ? 32'd0 : next_index[31:0];
        sum = {16'd0, base_offset} + {32'd0, pos} * stride_bytes();
        acc.addr = sum[47:0];
        acc.pos  = pos;
        expected_q.push_back(acc);
    endfunction

    function void check_result(logic [47:0] addr, logic [31:0] pos, logic last_of_pass);
        t_access want;
        if (expected_q.size() == 0) begin
            $error("result with no request outstanding: addr %h pos %h", addr, pos);
            errors++;
        end else begin
            want = expected_q.pop_front();
            if (addr !== want.addr) begin
                $error("byte_address mismatch: expected %h, actual %h", want.addr, addr);
                errors++;
            end
            if (pos !== want.pos) begin
                $error("block_position mismatch: expected %h, actual %h", want.pos, pos);
                errors++;
            end
            if (last_of_pass !== want.last_of_pass) begin
                $error("pass_end mismatch: expected %b, actual %b",
                       want.last_of_pass, last_of_pass);
                errors++;
            end
        end
    endfunction

    function int pending();
        return expected_q.size();
    endfunction
endclass

module tb_block_test_address_generator_core;

    localparam logic [btag_pkg::CFG_IDX_W-1:0] CFG_SPARE_6 = 3'd6;
    localparam logic [btag_pkg::CFG_IDX_W-1:0] CFG_SPARE_7 = 3'd7;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_index = '0;
    logic [47:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic        i_restart = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [47:0] o_byte_address;
    logic [31:0] o_block_position;
    logic        o_pass_end;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    addr_scoreboard sb = new();

    block_test_address_generator_core dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_restart        (i_restart),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_byte_address   (o_byte_address),
        .o_block_position (o_block_position),
        .o_pass_end       (o_pass_end)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready)
                sb.note_request(i_restart);
            if (o_out_valid && i_out_ready)
                sb.check_result(o_byte_address, o_block_position, o_pass_end);
        end
    end

    function automatic logic [47:0] rand48();
        logic [63:0] v;
        v = {$urandom(), $urandom()};
        return v[47:0];
    endfunction

    task automatic program_reg(logic [2:0] idx, logic [47:0] d);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
        sb.apply_setting(idx, d);
    endtask

    task automatic send_request(logic rs);
        if (send_idle_pct > 0) begin
            while ($urandom_range(0, 99) < send_idle_pct) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_in_valid <= 1'b1;
        i_restart  <= rs;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic wait_drained();
        while (sb.pending() != 0)
            @(posedge i_clk);
    endtask

    // a batch of transfers, then the sender holds off until all results are back
    task automatic run_batch(int n, int restart_pct);
        for (int k = 0; k < n; k++)
            send_request($urandom_range(0, 99) < restart_pct);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        wait_drained();
    endtask

    task automatic randomize_settings();
        logic [47:0] d;
        case ($urandom_range(0, 3))
            0: d = 48'($urandom_range(0, 64));
            1: d = 48'd1 << $urandom_range(0, 30);
            2: d = rand48();
            default: d = 48'($urandom_range(1, 32'h4000_0000));
        endcase
        program_reg(btag_pkg::CFG_BLOCK_SIZE, d);
        case ($urandom_range(0, 4))
            0: d = '0;
            1, 2: d = 48'd1 << $urandom_range(0, 30);
            3: d = 48'($urandom_range(0, 100));
            default: d = rand48();
        endcase
        program_reg(btag_pkg::CFG_ALIGN_BYTES, d);
        case ($urandom_range(0, 5))
            0: d = '0;
            1: d = '1;
            default: d = rand48();
        endcase
        program_reg(btag_pkg::CFG_BASE_OFFSET, d);
        case ($urandom_range(0, 5))
            0: d = rand48();
            1: d = 48'($urandom_range(0, 2));
            default: d = 48'($urandom_range(0, 20));
        endcase
        program_reg(btag_pkg::CFG_PASS_COUNT, d);
        if ($urandom_range(0, 4) == 0)
            d = rand48();
        else
            d = 48'($urandom_range(8, 32));
        program_reg(btag_pkg::CFG_LFSR_ORDER, d);
        d = ($urandom_range(0, 2) != 0) ? rand48() | 48'd1 : rand48() & ~48'd1;
        program_reg(btag_pkg::CFG_RANDOM_MODE, d);
    endtask

    initial begin
        int target;
        int count;
        int n;
        int rpct;
        int cut;

        send_idle_pct = 7;
        recv_idle_pct = 86;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // settings straight out of reset, restart in the middle
        run_batch(1, 0);
        run_batch(1, 100);
        run_batch(1, 0);

        // lfsr from zero, short pass, restart clears both
        program_reg(btag_pkg::CFG_RANDOM_MODE, 48'd1);
        program_reg(btag_pkg::CFG_LFSR_ORDER, 48'd8);
        program_reg(btag_pkg::CFG_PASS_COUNT, 48'd3);
        run_batch(3, 0);
        run_batch(1, 100);
        run_batch(2, 0);

        // widest order, largest sizes and an offset that wraps
        program_reg(btag_pkg::CFG_LFSR_ORDER, 48'd32);
        program_reg(btag_pkg::CFG_BASE_OFFSET, 48'hFFFF_FFFF_FFFF);
        program_reg(btag_pkg::CFG_BLOCK_SIZE, 48'hFFFF_FFFF_FFFF);
        program_reg(btag_pkg::CFG_ALIGN_BYTES, 48'h4000_0000);
        run_batch(2, 0);

        // order lowered with wide state left over
        program_reg(btag_pkg::CFG_LFSR_ORDER, 48'd8);
        run_batch(2, 0);

        // orders outside the tap table clamp to its ends
        program_reg(btag_pkg::CFG_LFSR_ORDER, 48'd0);
        run_batch(1, 0);
        program_reg(btag_pkg::CFG_LFSR_ORDER, 48'd63);
        run_batch(1, 0);
        program_reg(btag_pkg::CFG_LFSR_ORDER, 48'd7);
        run_batch(1, 0);
        program_reg(btag_pkg::CFG_LFSR_ORDER, 48'd33);
        run_batch(1, 0);

        // sequential: zero count, zero block size with non-power-of-two alignment
        program_reg(btag_pkg::CFG_RANDOM_MODE, 48'd0);
        program_reg(btag_pkg::CFG_PASS_COUNT, 48'd0);
        program_reg(btag_pkg::CFG_BLOCK_SIZE, 48'd0);
        program_reg(btag_pkg::CFG_ALIGN_BYTES, 48'd12);
        run_batch(2, 0);
        program_reg(btag_pkg::CFG_PASS_COUNT, 48'd5);
        program_reg(btag_pkg::CFG_ALIGN_BYTES, 48'd1);
        program_reg(btag_pkg::CFG_BLOCK_SIZE, 48'd1);
        run_batch(4, 0);
        // count lowered below the running index
        program_reg(btag_pkg::CFG_PASS_COUNT, 48'd2);
        run_batch(1, 0);

        // spare indexes must not disturb anything
        program_reg(CFG_SPARE_6, rand48());
        program_reg(CFG_SPARE_7, rand48());
        program_reg(btag_pkg::CFG_BLOCK_SIZE, 48'h4000_0000);
        program_reg(btag_pkg::CFG_ALIGN_BYTES, 48'h4000_0000);
        program_reg(btag_pkg::CFG_RANDOM_MODE, 48'd1);
        program_reg(btag_pkg::CFG_LFSR_ORDER, 48'd16);
        run_batch(1, 100);

        for (int regime = 0; regime < 3; regime++) begin
            case (regime)
                0: begin
                    send_idle_pct = 7;
                    recv_idle_pct = 86;
                    target = 180;
                end
                1: begin
                    send_idle_pct = 86;
                    recv_idle_pct = 7;
                    target = 180;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    target = 290;
                end
            endcase
            count = 0;
            if (regime == 2) begin
                // full order-8 period so the seed-to-zero step comes round
                randomize_settings();
                program_reg(btag_pkg::CFG_LFSR_ORDER, 48'd8);
                program_reg(btag_pkg::CFG_RANDOM_MODE, 48'd1);
                run_batch(1, 100);
                run_batch(264, 0);
                count = 265;
            end
            while (count < target) begin
                randomize_settings();
                n = $urandom_range(5, 40);
                case ($urandom_range(0, 2))
                    0: rpct = 0;
                    1: rpct = 3;
                    default: rpct = 15;
                endcase
                cut = $urandom_range(1, n);
                run_batch(cut, rpct);
                if (cut < n)
                    run_batch(n - cut, rpct);
                count += n;
            end
        end

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
